### design/nre_pkg.sv
// Shared types and codes for the node recovery escalation controller.
package nre_pkg;

  typedef enum logic [3:0] {
    ST_LVL0      = 4'd0,
    ST_LVL2      = 4'd1,
    ST_LVL3      = 4'd2,
    ST_REPAIR    = 4'd3,
    ST_STARTING  = 4'd4,
    ST_ASSIGNING = 4'd5,
    ST_LEAVE_FO  = 4'd6,
    ST_WAIT_JOIN = 4'd7,
    ST_GRACE_FO  = 4'd8,
    ST_REBOOTING = 4'd9
  } node_st_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_START       = 3'd1,
    ACT_ASSIGN      = 3'd2,
    ACT_LEFT_FO     = 3'd3,
    ACT_GRACE_FO    = 3'd4,
    ACT_REBOOT      = 3'd5,
    ACT_RESTART_SU  = 3'd6,
    ACT_FAILOVER_SU = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    CMD_LEAVE        = 3'd0,
    CMD_FAILOVER     = 3'd1,
    CMD_COMP_RESTART = 3'd2,
    CMD_COMP_FO      = 3'd3,
    CMD_SYNC_READY   = 3'd4,
    CMD_APPS_STARTED = 3'd5,
    CMD_ASSIGNED     = 3'd6,
    CMD_SG_FO        = 3'd7
  } cmd_t;

  localparam int CNT_W = 16;
  localparam logic [0:0] REG_UNIT_FO_LIMIT = 1'b0;
  localparam logic [CNT_W-1:0] UNIT_FO_LIMIT_RST = 16'hFFFF;

  // One event's operand fields.
  typedef struct packed {
    logic [CNT_W-1:0] restart_count;
    logic [CNT_W-1:0] restart_limit;
    logic [CNT_W-1:0] failover_count;
    logic             unit_failover_allowed;
    logic             apps_started;
    logic             apps_assigned;
    logic             groups_idle;
  } evt_t;

  // Current node state handed to the step logic.
  typedef struct packed {
    node_st_t node_state;
    node_st_t return_state;
    logic     enabled;
  } node_ctx_t;

  // Step outcome: result fields plus next state.
  typedef struct packed {
    action_t  action;
    node_st_t node_state;
    node_st_t return_state;
    logic     enabled;
    logic     disable_unit;
    logic     fault;
  } step_res_t;

endpackage

### design/nre_step.sv
// Next-state and action logic for one event.
module nre_step (
  input  nre_pkg::cmd_t            cmd,
  input  nre_pkg::evt_t            evt,
  input  nre_pkg::node_ctx_t       ctx,
  input  logic [nre_pkg::CNT_W-1:0] unit_failover_limit,
  output nre_pkg::step_res_t       res
);
  import nre_pkg::*;

  logic idle_st;
  logic restart_hit;
  logic unit_fo_left;

  assign idle_st      = ctx.node_state inside {ST_LVL0, ST_LVL2, ST_LVL3};
  assign restart_hit  = evt.restart_count >= evt.restart_limit;
  assign unit_fo_left = evt.failover_count < unit_failover_limit;

  always_comb begin
    res.action       = ACT_NONE;
    res.node_state   = ctx.node_state;
    res.return_state = ctx.return_state;
    res.enabled      = ctx.enabled;
    res.disable_unit = 1'b0;
    res.fault        = 1'b0;
    case (cmd)
      CMD_LEAVE: begin
        if (idle_st) begin
          res.enabled    = 1'b0;
          res.node_state = ST_LEAVE_FO;
          res.action     = ACT_LEFT_FO;
        end else if (ctx.node_state == ST_REBOOTING) begin
          res.enabled    = 1'b1;
          res.node_state = ctx.return_state;
        end else if (ctx.node_state != ST_REPAIR) begin
          res.fault = 1'b1;
        end
      end
      CMD_FAILOVER: begin
        if (idle_st) begin
          res.node_state = ST_GRACE_FO;
          res.action     = ACT_GRACE_FO;
        end else if (ctx.node_state != ST_REPAIR) begin
          res.fault = 1'b1;
        end
      end
      CMD_COMP_RESTART, CMD_COMP_FO: begin
        if (ctx.node_state inside {ST_LVL0, ST_LVL2}) begin
          if (cmd == CMD_COMP_FO) begin
            if (evt.unit_failover_allowed) res.action = ACT_FAILOVER_SU;
          end else if (restart_hit) begin
            res.node_state   = ST_LVL3;
            res.disable_unit = 1'b1;
            res.action       = ACT_FAILOVER_SU;
          end else begin
            res.node_state = ST_LVL2;
            res.action     = ACT_RESTART_SU;
          end
        end else if (ctx.node_state == ST_LVL3) begin
          if (!unit_fo_left) begin
            // Unit failover budget spent: escalate to node failover.
            res.return_state = ST_LVL0;
            res.node_state   = ST_GRACE_FO;
            res.action       = ACT_GRACE_FO;
          end else if (cmd == CMD_COMP_FO) begin
            if (evt.unit_failover_allowed) res.action = ACT_FAILOVER_SU;
          end else begin
            res.disable_unit = 1'b1;
            res.action       = ACT_FAILOVER_SU;
          end
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_SYNC_READY: begin
        if (idle_st || ctx.node_state == ST_WAIT_JOIN) begin
          res.enabled    = 1'b1;
          res.node_state = ST_STARTING;
          res.action     = ACT_START;
        end else if (ctx.node_state == ST_REPAIR) begin
          res.enabled = 1'b1;
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_APPS_STARTED: begin
        if (ctx.node_state == ST_STARTING) begin
          if (evt.apps_started) begin
            res.node_state = ST_ASSIGNING;
            res.action     = ACT_ASSIGN;
          end
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_ASSIGNED: begin
        if (ctx.node_state == ST_ASSIGNING) begin
          if (evt.apps_assigned) res.node_state = ctx.return_state;
        end else begin
          res.fault = 1'b1;
        end
      end
      default: begin
        if (ctx.node_state == ST_LEAVE_FO) begin
          if (evt.groups_idle) res.node_state = ST_WAIT_JOIN;
        end else if (ctx.node_state == ST_GRACE_FO) begin
          if (evt.groups_idle) begin
            res.node_state = ST_REBOOTING;
            res.action     = ACT_REBOOT;
          end
        end else if (ctx.node_state != ST_WAIT_JOIN) begin
          res.fault = 1'b1;
        end
      end
    endcase
  end

endmodule

### design/node_recovery_escalation_fsm.sv
// Top level: node recovery escalation controller with stream ports and register port.
// Path: a word accepted at a rising edge is held in the input stage, then loaded into the result
//   register and shown on out_tdata; one word per cycle is sustained when out_tready stays high.
// The combinational path is the event decode in nre_step feeding the state and result registers.
// Reset (rst_n low, synchronous): both pipeline stages empty, node and return state at level
//   zero, node operational, unit failover limit at 65535.
module node_recovery_escalation_fsm (
  input  logic        clk,
  input  logic        rst_n,
  // Event stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] restart_count, [31:16] restart_limit, [47:32] failover_count,
  // [48] unit_failover_allowed, [49] apps_started, [50] apps_assigned, [51] groups_idle
  input  logic [55:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] action, [6:3] new_state, [7] oper_enabled, [8] disable_unit, [9] fault
  output logic [15:0] out_tdata,
  // Register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nre_pkg::*;

  // Input stage: holds one captured word until the step stage takes it.
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  evt_t              s1_evt_r;

  // Node state, updated once per word as it passes the step stage.
  node_st_t          node_state_r;
  node_st_t          return_state_r;
  logic              enabled_r;

  // Result register.
  logic              out_valid_r;
  action_t           out_action_r;
  node_st_t          out_state_r;
  logic              out_enabled_r;
  logic              out_disable_r;
  logic              out_fault_r;

  logic [CNT_W-1:0]  ufo_limit_r;

  logic              s2_ready;
  logic              step_go;
  logic              cfg_wr;
  evt_t              in_evt;
  node_ctx_t         ctx;
  step_res_t         res;

  // The result register frees up when empty or when its word is taken this cycle.
  assign s2_ready  = !out_valid_r || out_tready;
  assign step_go   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  // Unpack the event fields, lowest bits first.
  assign in_evt.restart_count         = in_tdata[15:0];
  assign in_evt.restart_limit         = in_tdata[31:16];
  assign in_evt.failover_count        = in_tdata[47:32];
  assign in_evt.unit_failover_allowed = in_tdata[48];
  assign in_evt.apps_started          = in_tdata[49];
  assign in_evt.apps_assigned         = in_tdata[50];
  assign in_evt.groups_idle           = in_tdata[51];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload needs no reset; capture only on an accepted word.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r <= cmd_t'(in_tuser);
      s1_evt_r <= in_evt;
    end
  end

  assign ctx.node_state   = node_state_r;
  assign ctx.return_state = return_state_r;
  assign ctx.enabled      = enabled_r;

  nre_step u_step (
    .cmd                 (s1_cmd_r),
    .evt                 (s1_evt_r),
    .ctx                 (ctx),
    .unit_failover_limit (ufo_limit_r),
    .res                 (res)
  );

  // Advance node state and load the result register together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_state_r   <= ST_LVL0;
      return_state_r <= ST_LVL0;
      enabled_r      <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (step_go) begin
        node_state_r   <= res.node_state;
        return_state_r <= res.return_state;
        enabled_r      <= res.enabled;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_action_r  <= res.action;
      out_state_r   <= res.node_state;
      out_enabled_r <= res.enabled;
      out_disable_r <= res.disable_unit;
      out_fault_r   <= res.fault;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_fault_r, out_disable_r, out_enabled_r, out_state_r,
                       out_action_r};

  // Register port: write in the access phase, reads return the limit at its address, else zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ufo_limit_r <= UNIT_FO_LIMIT_RST;
    end else if (cfg_wr && cfg_paddr[2:2] == REG_UNIT_FO_LIMIT) begin
      ufo_limit_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2:2] == REG_UNIT_FO_LIMIT) begin
      cfg_prdata = {{(32-CNT_W){1'b0}}, ufo_limit_r};
    end
  end

  // A rejected event carries no action and marks nothing disabled.
  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && res.fault |=> out_action_r == ACT_NONE && !out_disable_r)
    else $error("fault result carries an action");

  // A disable mark only comes with a unit failover.
  a_disable_fo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_disable_r |-> out_action_r == ACT_FAILOVER_SU)
    else $error("disable mark without unit failover");

  // A fault leaves all node state untouched.
  a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && res.fault |=> $stable(node_state_r) && $stable(return_state_r)
      && $stable(enabled_r))
    else $error("fault changed node state");

  // The result shown matches the registered node state right after it is made.
  a_state_echo: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> out_state_r == node_state_r && out_enabled_r == enabled_r)
    else $error("result state differs from node state");

  // Input stage only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready && s1_valid_r)
    else $error("input stalled without back pressure");

endmodule

### verif/tb.sv
// Self-checking testbench for the node recovery escalation controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nre_pkg::*;

  // Byte addresses on the register port: the limit register and an unused slot.
  localparam logic [2:0] ADDR_FO_LIMIT = {REG_UNIT_FO_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_SPARE    = 3'd4;
  localparam int         LONG_HOLD     = 80;
  localparam int         PHASE_HALF    = 72;

  // One event word as queued for the driver.
  typedef struct packed {
    cmd_t cmd;
    evt_t ev;
  } ev_word_t;

  // Expected result word of one event.
  typedef struct packed {
    action_t  action;
    node_st_t state;
    logic     oper;
    logic     disable_unit;
    logic     fault;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  node_recovery_escalation_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the node: availability state, history state, operational flag, limit.
  node_st_t    node_st  = ST_LVL0;
  node_st_t    ret_st   = ST_LVL0;
  logic        node_up  = 1'b1;
  logic [15:0] fo_limit = UNIT_FO_LIMIT_RST;

  ev_word_t event_q[$];    // words waiting for the driver
  verdict_t verdict_q[$];  // predicted result words, oldest first
  ev_word_t cur_word;

  bit calm      = 1'b0;    // set for the last phase: no idling on either side
  bit long_hold = 1'b0;    // request one long receiver stall
  int gap_left  = 0;
  int stall_left = 0;
  int n_err = 0, n_words = 0, n_checked = 0;
  int n_fault = 0, n_reboot = 0, n_grace = 0, n_unit_fo = 0, n_settings = 0;

  // Compute the result of one event and advance the shadow node.
  function automatic verdict_t advance_node(cmd_t c, evt_t e);
    verdict_t v;
    node_st_t s;
    logic     lvl;
    action_t  act;
    logic     dis;
    logic     flt;
    s   = node_st;
    lvl = (s == ST_LVL0) || (s == ST_LVL2) || (s == ST_LVL3);
    act = ACT_NONE;
    dis = 1'b0;
    flt = 1'b0;
    case (c)
      CMD_LEAVE: begin
        if (lvl) begin
          node_up = 1'b0;
          node_st = ST_LEAVE_FO;
          act     = ACT_LEFT_FO;
        end else if (s == ST_REBOOTING) begin
          node_up = 1'b1;
          node_st = ret_st;
        end else if (s != ST_REPAIR) begin
          flt = 1'b1;
        end
      end
      CMD_FAILOVER: begin
        if (lvl) begin
          node_st = ST_GRACE_FO;
          act     = ACT_GRACE_FO;
        end else if (s != ST_REPAIR) begin
          flt = 1'b1;
        end
      end
      CMD_COMP_RESTART: begin
        // At level zero the restart is judged as at level two.
        if (s == ST_LVL0 || s == ST_LVL2) begin
          if (e.restart_count >= e.restart_limit) begin
            node_st = ST_LVL3;
            dis     = 1'b1;
            act     = ACT_FAILOVER_SU;
          end else begin
            node_st = ST_LVL2;
            act     = ACT_RESTART_SU;
          end
        end else if (s == ST_LVL3) begin
          if (e.failover_count < fo_limit) begin
            dis = 1'b1;
            act = ACT_FAILOVER_SU;
          end else begin
            ret_st  = ST_LVL0;
            node_st = ST_GRACE_FO;
            act     = ACT_GRACE_FO;
          end
        end else begin
          flt = 1'b1;
        end
      end
      CMD_COMP_FO: begin
        if (s == ST_LVL0 || s == ST_LVL2) begin
          if (e.unit_failover_allowed) act = ACT_FAILOVER_SU;
        end else if (s == ST_LVL3) begin
          if (e.failover_count < fo_limit) begin
            if (e.unit_failover_allowed) act = ACT_FAILOVER_SU;
          end else begin
            ret_st  = ST_LVL0;
            node_st = ST_GRACE_FO;
            act     = ACT_GRACE_FO;
          end
        end else begin
          flt = 1'b1;
        end
      end
      CMD_SYNC_READY: begin
        if (lvl || s == ST_WAIT_JOIN) begin
          node_up = 1'b1;
          node_st = ST_STARTING;
          act     = ACT_START;
        end else if (s == ST_REPAIR) begin
          node_up = 1'b1;
        end else begin
          flt = 1'b1;
        end
      end
      CMD_APPS_STARTED: begin
        if (s == ST_STARTING) begin
          if (e.apps_started) begin
            node_st = ST_ASSIGNING;
            act     = ACT_ASSIGN;
          end
        end else begin
          flt = 1'b1;
        end
      end
      CMD_ASSIGNED: begin
        if (s == ST_ASSIGNING) begin
          if (e.apps_assigned) node_st = ret_st;
        end else begin
          flt = 1'b1;
        end
      end
      default: begin
        // Group failed over: wait-join takes it silently.
        if (s == ST_LEAVE_FO) begin
          if (e.groups_idle) node_st = ST_WAIT_JOIN;
        end else if (s == ST_GRACE_FO) begin
          if (e.groups_idle) begin
            node_st = ST_REBOOTING;
            act     = ACT_REBOOT;
          end
        end else if (s != ST_WAIT_JOIN) begin
          flt = 1'b1;
        end
      end
    endcase
    v.action       = act;
    v.state        = node_st;
    v.oper         = node_up;
    v.disable_unit = dis;
    v.fault        = flt;
    return v;
  endfunction

  // flags, lowest bit up: unit_failover_allowed, apps_started, apps_assigned, groups_idle
  function automatic evt_t mk(logic [15:0] rc, logic [15:0] rl, logic [15:0] fc,
                              logic [3:0] flags);
    evt_t e;
    e.restart_count  = rc;
    e.restart_limit  = rl;
    e.failover_count = fc;
    {e.groups_idle, e.apps_assigned, e.apps_started, e.unit_failover_allowed} = flags;
    return e;
  endfunction

  function automatic void put(cmd_t c, evt_t e);
    ev_word_t w;
    w.cmd = c;
    w.ev  = e;
    event_q.push_back(w);
  endfunction

  // Counts: mostly small so comparisons go both ways, sometimes extremes or full range.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic evt_t rand_fields();
    return mk(pick_count(), pick_count(), pick_count(), 4'($urandom_range(0, 15)));
  endfunction

  // Push a guarded event: sometimes first with the guard false, then with it true.
  function automatic int put_guarded(cmd_t c);
    evt_t e;
    int   n;
    n = 0;
    e = rand_fields();
    if ($urandom_range(0, 3) == 0) begin
      {e.groups_idle, e.apps_assigned, e.apps_started} = 3'b000;
      put(c, e);
      n++;
    end
    {e.groups_idle, e.apps_assigned, e.apps_started} = 3'b111;
    put(c, e);
    return n + 1;
  endfunction

  // Queue one recovery sequence with random content; returns the number of words.
  function automatic int push_scenario();
    evt_t e;
    int   n;
    int   k;
    n = 0;
    case ($urandom_range(0, 5))
      0, 1: begin
        // escalate: restarts and failover requests with counts near the limits
        k = $urandom_range(1, 6);
        repeat (k) begin
          e = rand_fields();
          e.restart_count  = 16'($urandom_range(0, 3));
          e.restart_limit  = 16'($urandom_range(0, 3));
          if ($urandom_range(0, 4) != 0) e.failover_count = 16'($urandom_range(0, 4));
          put(cmd_t'(($urandom_range(0, 3) == 0) ? CMD_COMP_FO : CMD_COMP_RESTART), e);
          n++;
        end
        if ($urandom_range(0, 1) == 0) begin
          n += put_guarded(CMD_SG_FO);
          put(CMD_LEAVE, rand_fields());
          n++;
        end
      end
      2: begin
        // leave, wait for groups, rejoin and bring the applications back
        put(CMD_LEAVE, rand_fields());
        n++;
        n += put_guarded(CMD_SG_FO);
        if ($urandom_range(0, 3) == 0) begin
          put(CMD_SG_FO, rand_fields());
          n++;
        end
        put(CMD_SYNC_READY, rand_fields());
        n++;
        n += put_guarded(CMD_APPS_STARTED);
        n += put_guarded(CMD_ASSIGNED);
      end
      3: begin
        // graceful node failover through reboot and back
        put(CMD_FAILOVER, rand_fields());
        n++;
        n += put_guarded(CMD_SG_FO);
        put(CMD_LEAVE, rand_fields());
        n++;
        if ($urandom_range(0, 1) == 0) begin
          put(CMD_SYNC_READY, rand_fields());
          n++;
          n += put_guarded(CMD_APPS_STARTED);
          n += put_guarded(CMD_ASSIGNED);
        end
      end
      default: begin
        // noise: anything in any state
        k = $urandom_range(1, 3);
        repeat (k) begin
          put(cmd_t'($urandom_range(0, 7)), rand_fields());
          n++;
        end
      end
    endcase
    return n;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  // Driver: hold a word until it is taken, predict at acceptance, idle in short bursts.
  always @(posedge clk) begin : drive_events
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(advance_node(cur_word.cmd, cur_word.ev));
        n_words++;
      end
      if (!in_tvalid || in_tready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_q.size() != 0) begin
          if (!calm && $urandom_range(0, 6) == 0) begin
            gap_left = $urandom_range(0, 3);
          end else begin
            cur_word = event_q.pop_front();
            nv = 1'b1;
            in_tdata <= {4'b0000, cur_word.ev.groups_idle, cur_word.ev.apps_assigned,
                         cur_word.ev.apps_started, cur_word.ev.unit_failover_allowed,
                         cur_word.ev.failover_count, cur_word.ev.restart_limit,
                         cur_word.ev.restart_count};
            in_tuser <= cur_word.cmd;
          end
        end
        in_tvalid <= nv;
      end
    end
  end

  // Monitor: check each result word against the oldest prediction, stall in bursts.
  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word %h with no event pending", out_tdata);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          check_field("action", 4'(want.action), 4'(out_tdata[2:0]));
          check_field("new_state", 4'(want.state), out_tdata[6:3]);
          check_field("oper_enabled", 4'(want.oper), 4'(out_tdata[7]));
          check_field("disable_unit", 4'(want.disable_unit), 4'(out_tdata[8]));
          check_field("fault", 4'(want.fault), 4'(out_tdata[9]));
          n_checked++;
          if (want.fault) n_fault++;
          if (want.action == ACT_REBOOT) n_reboot++;
          if (want.action == ACT_GRACE_FO) n_grace++;
          if (want.action == ACT_FAILOVER_SU) n_unit_fo++;
        end
      end
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Wait until the driver is empty and every predicted word has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (event_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the value at the access edge.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_FO_LIMIT) fo_limit = data[15:0];
  endtask

  // Read the limit back at the access edge and compare with the shadow copy.
  task automatic check_limit_reg();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_FO_LIMIT;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'h0000, fo_limit}) begin
      $error("unit_failover_limit: expected %0d, got %0d", fo_limit, cfg_prdata);
      n_err++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin : limit_run
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] lim;
    int          n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset value, then a write to the unused slot must leave the limit alone.
    check_limit_reg();
    write_reg(ADDR_SPARE, 32'h0000_0000);
    check_limit_reg();

    // Directed: walk every event through the escalation levels and phases.
    put(CMD_SG_FO,        mk(16'h0000, 16'h0000, 16'h0000, 4'b1111)); // fault at lvl0
    put(CMD_APPS_STARTED, mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111)); // fault
    put(CMD_ASSIGNED,     mk(16'h0000, 16'h0000, 16'h0000, 4'b1111)); // fault
    put(CMD_COMP_FO,      mk(16'hFFFF, 16'h0000, 16'h0000, 4'b0000)); // unit fo not allowed
    put(CMD_COMP_FO,      mk(16'h0000, 16'hFFFF, 16'hFFFF, 4'b0001)); // unit fo
    put(CMD_COMP_RESTART, mk(16'h0000, 16'hFFFF, 16'h0000, 4'b0000)); // lvl0 -> lvl2 restart
    put(CMD_COMP_RESTART, mk(16'hFFFF, 16'hFFFF, 16'h0000, 4'b1110)); // -> lvl3
    put(CMD_COMP_RESTART, mk(16'h0000, 16'h0000, 16'hFFFE, 4'b0000)); // below limit
    put(CMD_COMP_FO,      mk(16'h0000, 16'h0000, 16'h0000, 4'b1110)); // not allowed at lvl3
    put(CMD_COMP_FO,      mk(16'h0000, 16'h0000, 16'hFFFF, 4'b0001)); // limit reached
    put(CMD_COMP_RESTART, mk(16'h0000, 16'hFFFF, 16'h0000, 4'b1111)); // fault in grace
    put(CMD_LEAVE,        mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // fault
    put(CMD_FAILOVER,     mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // fault
    put(CMD_SYNC_READY,   mk(16'h0000, 16'h0000, 16'h0000, 4'b1111)); // fault
    put(CMD_SG_FO,        mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0111)); // groups busy
    put(CMD_SG_FO,        mk(16'h0000, 16'h0000, 16'h0000, 4'b1000)); // reboot
    put(CMD_LEAVE,        mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // back to lvl0
    put(CMD_LEAVE,        mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111)); // leave-failover
    put(CMD_SYNC_READY,   mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // fault, stays down
    put(CMD_SG_FO,        mk(16'h0000, 16'h0000, 16'h0000, 4'b1000)); // wait-join
    put(CMD_SG_FO,        mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // ignored in wait-join
    put(CMD_SYNC_READY,   mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // starting
    put(CMD_APPS_STARTED, mk(16'h0000, 16'h0000, 16'h0000, 4'b1101)); // guard false
    put(CMD_APPS_STARTED, mk(16'h0000, 16'h0000, 16'h0000, 4'b0010)); // assigning
    put(CMD_ASSIGNED,     mk(16'h0000, 16'h0000, 16'h0000, 4'b1011)); // guard false
    put(CMD_ASSIGNED,     mk(16'h0000, 16'h0000, 16'h0000, 4'b0100)); // back to lvl0
    put(CMD_FAILOVER,     mk(16'h0000, 16'h0000, 16'h0000, 4'b0000)); // grace
    wait_idle();

    // Random phases, each under its own limit; extremes first.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 16'h0000;
        1:       lim = 16'hFFFF;
        2:       lim = 16'd1;
        3:       lim = 16'd2;
        4:       lim = 16'($urandom_range(0, 5));
        default: lim = 16'($urandom);
      endcase
      write_reg(ADDR_FO_LIMIT, {16'($urandom), lim});
      check_limit_reg();
      n_settings++;
      if (p == 5) @(negedge clk) calm = 1'b1;
      // Fill in two halves; the sender pauses in between until the pipe drains.
      repeat (2) begin
        n = 0;
        while (n < PHASE_HALF) n += push_scenario();
        // Hold the receiver off once while words keep coming.
        if (p == 1) @(negedge clk) long_hold = 1'b1;
        wait_idle();
      end
    end

    repeat (10) @(negedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d predicted result words never arrived", verdict_q.size());
      n_err++;
    end
    $display("Run: %0d event words, %0d results checked under %0d limit settings.",
             n_words, n_checked, n_settings);
    $display("Seen: %0d faults, %0d unit failovers, %0d node failovers, %0d reboots.",
             n_fault, n_unit_fo, n_grace, n_reboot);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
